// File: rtl/assert_macros.svh
// Assertion macros shared by the vector unit RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define VVU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property, checked during reset too.
`define VVU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/vvu_pkg.sv
// Shared types, constants and helpers of the vector unit.
// No dependencies.
package vvu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQ_NW    = 66;
  localparam int unsigned SQ_RW    = 36;
  localparam int unsigned SQ_QW    = 33;
  localparam int unsigned SQ_STEPS = 33;
  localparam int unsigned DIV_DW   = 33;
  localparam int unsigned DIV_RW   = 34;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_SCALE     = 3'd2,
    OP_NEGATE    = 3'd3,
    OP_NORMALIZE = 3'd4,
    OP_PERSP     = 3'd5,
    OP_EQUALS    = 3'd6
  } op_e;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    op_e             op;
    logic [3:0][31:0] a;
    logic            eq;
    logic [3:0][31:0] er;
    logic            esat;
  } side_t;

  // {clamped flag, clamped value}
  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sh7FFFFFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sh80000000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/vvu_sqrt_cell.sv
// One digit step of the pipelined integer square root.
// Depends on vvu_pkg.
module vvu_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  vvu_pkg::side_t             side_i,
  input  logic [vvu_pkg::SQ_NW-1:0]  n_i,
  input  logic [vvu_pkg::SQ_RW-1:0]  rem_i,
  input  logic [vvu_pkg::SQ_QW-1:0]  root_i,
  output logic                       vld_o,
  output vvu_pkg::side_t             side_o,
  output logic [vvu_pkg::SQ_NW-1:0]  n_o,
  output logic [vvu_pkg::SQ_RW-1:0]  rem_o,
  output logic [vvu_pkg::SQ_QW-1:0]  root_o
);

  logic [vvu_pkg::SQ_RW-1:0] rem_sh, trial, rem_d;
  logic [vvu_pkg::SQ_QW-1:0] root_d;
  logic [vvu_pkg::SQ_NW-1:0] n_d;
  logic                      ge;
  logic                      vld_q;

  always_comb begin
    rem_sh = {rem_i[vvu_pkg::SQ_RW-3:0], n_i[vvu_pkg::SQ_NW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? rem_sh - trial : rem_sh;
    root_d = {root_i[vvu_pkg::SQ_QW-2:0], ge};
    n_d    = {n_i[vvu_pkg::SQ_NW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      n_o    <= n_d;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

  assign vld_o = vld_q;

endmodule

// File: rtl/vvu_div_cell.sv
// One quotient bit step of the pipelined reciprocal divider.
// Depends on vvu_pkg.
module vvu_div_cell #(
  parameter int unsigned QW   = 33,
  parameter bit          LEAD = 1'b0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  vvu_pkg::side_t              side_i,
  input  logic [vvu_pkg::DIV_DW-1:0]  d_i,
  input  logic [vvu_pkg::DIV_RW-1:0]  rem_i,
  input  logic [QW-1:0]               q_i,
  output logic                        vld_o,
  output vvu_pkg::side_t              side_o,
  output logic [vvu_pkg::DIV_DW-1:0]  d_o,
  output logic [vvu_pkg::DIV_RW-1:0]  rem_o,
  output logic [QW-1:0]               q_o
);

  logic [vvu_pkg::DIV_RW-1:0] rem_sh, dx, rem_d;
  logic [QW-1:0]              q_d;
  logic                       ge;
  logic                       vld_q;

  always_comb begin
    rem_sh = {rem_i[vvu_pkg::DIV_RW-2:0], LEAD};
    dx     = {1'b0, d_i};
    ge     = rem_sh >= dx;
    rem_d  = ge ? rem_sh - dx : rem_sh;
    q_d    = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      d_o    <= d_i;
      rem_o  <= rem_d;
      q_o    <= q_d;
    end
  end

  assign vld_o = vld_q;

endmodule

// File: rtl/vec4_vector_unit.sv
// Top level of the four-component Q-format vector unit.
// Depends on vvu_pkg, vvu_sqrt_cell, vvu_div_cell and assert_macros.svh.
//
// Accepts one beat per cycle whenever in_ready_o is high and returns one result
// beat per input beat, in order, through three front stages (input, squares
// and products, sum), a row of 33 square-root cells, a row of 2*FRAC_BITS+1
// reciprocal divider cells, one multiply stage and the output register. Every
// stage only holds when the one after it is full and stalled, so empty stages
// keep filling while a result waits at the output.
`include "assert_macros.svh"

module vec4_vector_unit #(
  parameter int unsigned FRAC_BITS = vvu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] a_w_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] b_w_i,
  input  logic signed [31:0] scalar_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] r_x_o,
  output logic signed [31:0] r_y_o,
  output logic signed [31:0] r_z_o,
  output logic signed [31:0] r_w_o,
  output logic               equal_o,
  output logic               div_zero_o,
  output logic               saturated_o
);

  localparam int unsigned QW    = 2 * FRAC_BITS + 1;
  localparam int unsigned QE    = (QW > 33) ? QW : 33;
  localparam int unsigned SQ0   = 3;
  localparam int unsigned DV0   = SQ0 + vvu_pkg::SQ_STEPS;
  localparam int unsigned SM    = DV0 + QW;
  localparam int unsigned SO    = SM + 1;
  localparam int unsigned NS    = SO + 1;

  wire  [NS-1:0] vld;
  logic [NS-1:0] en;
  logic          v0_q, v1_q, v2_q, vm_q, vo_q;

  assign vld[0]  = v0_q;
  assign vld[1]  = v1_q;
  assign vld[2]  = v2_q;
  assign vld[SM] = vm_q;
  assign vld[SO] = vo_q;

  assign en[NS-1] = !vld[NS-1] | out_ready_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] | en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en[0])  v0_q <= in_valid_i;
      if (en[1])  v1_q <= vld[0];
      if (en[2])  v2_q <= vld[1];
      if (en[SM]) vm_q <= vld[SM-1];
      if (en[SO]) vo_q <= vld[SM];
    end
  end

  // input register
  vvu_pkg::op_e  s0_op;
  vvu_pkg::word_t s0_a [4];
  vvu_pkg::word_t s0_b [4];
  vvu_pkg::word_t s0_s;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_op   <= vvu_pkg::op_e'(operation_i);
      s0_a[0] <= a_x_i;
      s0_a[1] <= a_y_i;
      s0_a[2] <= a_z_i;
      s0_a[3] <= a_w_i;
      s0_b[0] <= b_x_i;
      s0_b[1] <= b_y_i;
      s0_b[2] <= b_z_i;
      s0_b[3] <= b_w_i;
      s0_s    <= scalar_i;
    end
  end

  // squares and scale products
  vvu_pkg::op_e       s1_op;
  vvu_pkg::word_t     s1_a [4];
  vvu_pkg::word_t     s1_b [4];
  logic               s1_eq;
  logic [63:0]        s1_sq [4];
  logic signed [63:0] s1_scp [4];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_op <= s0_op;
      s1_eq <= (s0_a[0] == s0_b[0]) && (s0_a[1] == s0_b[1]) &&
               (s0_a[2] == s0_b[2]) && (s0_a[3] == s0_b[3]);
      for (int i = 0; i < 4; i++) begin
        s1_a[i]   <= s0_a[i];
        s1_b[i]   <= s0_b[i];
        s1_sq[i]  <= $signed(s0_a[i]) * $signed(s0_a[i]);
        s1_scp[i] <= $signed(s0_a[i]) * $signed(s0_s);
      end
    end
  end

  // sum of squares and the simple operations
  vvu_pkg::side_t            s2_side_d, s2_side;
  logic [vvu_pkg::SQ_NW-1:0] s2_n;
  logic [64:0]               sum_d;

  always_comb begin
    logic signed [65:0] v;
    logic [32:0]        sr;
    logic signed [63:0] sc;
    s2_side_d.op   = s1_op;
    s2_side_d.eq   = s1_eq;
    s2_side_d.esat = 1'b0;
    sum_d = 65'(s1_sq[0]) + 65'(s1_sq[1]) + 65'(s1_sq[2]) + 65'(s1_sq[3]);
    for (int i = 0; i < 4; i++) begin
      s2_side_d.a[i] = s1_a[i];
      sc = s1_scp[i] >>> FRAC_BITS;
      unique case (s1_op)
        vvu_pkg::OP_ADD:    v = 66'($signed(s1_a[i])) + 66'($signed(s1_b[i]));
        vvu_pkg::OP_SUB:    v = 66'($signed(s1_a[i])) - 66'($signed(s1_b[i]));
        vvu_pkg::OP_SCALE:  v = 66'(sc);
        vvu_pkg::OP_NEGATE: v = -66'($signed(s1_a[i]));
        default:            v = '0;
      endcase
      sr = vvu_pkg::sat66(v);
      s2_side_d.er[i] = sr[31:0];
      s2_side_d.esat  = s2_side_d.esat | sr[32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_side <= s2_side_d;
      s2_n    <= {1'b0, sum_d};
    end
  end

  // square root row
  vvu_pkg::side_t            sq_side [vvu_pkg::SQ_STEPS+1];
  logic [vvu_pkg::SQ_NW-1:0] sq_n    [vvu_pkg::SQ_STEPS+1];
  logic [vvu_pkg::SQ_RW-1:0] sq_rem  [vvu_pkg::SQ_STEPS+1];
  logic [vvu_pkg::SQ_QW-1:0] sq_root [vvu_pkg::SQ_STEPS+1];

  assign sq_side[0] = s2_side;
  assign sq_n[0]    = s2_n;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < vvu_pkg::SQ_STEPS; i++) begin : g_sqrt
    vvu_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[SQ0+i]),
      .vld_i  (vld[SQ0+i-1]),
      .side_i (sq_side[i]),
      .n_i    (sq_n[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .vld_o  (vld[SQ0+i]),
      .side_o (sq_side[i+1]),
      .n_o    (sq_n[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // divisor: length for normalize, |w| otherwise
  vvu_pkg::side_t             dv_side [QW+1];
  logic [vvu_pkg::DIV_DW-1:0] dv_d    [QW+1];
  logic [vvu_pkg::DIV_RW-1:0] dv_rem  [QW+1];
  logic [QW-1:0]              dv_q    [QW+1];
  logic [31:0]                aw_end;

  assign aw_end     = sq_side[vvu_pkg::SQ_STEPS].a[3];
  assign dv_side[0] = sq_side[vvu_pkg::SQ_STEPS];
  assign dv_d[0]    = (sq_side[vvu_pkg::SQ_STEPS].op == vvu_pkg::OP_NORMALIZE) ?
                      sq_root[vvu_pkg::SQ_STEPS] :
                      (aw_end[31] ? 33'd0 - {1'b1, aw_end} : {1'b0, aw_end});
  assign dv_rem[0]  = '0;
  assign dv_q[0]    = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    vvu_div_cell #(
      .QW   (QW),
      .LEAD (j == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[DV0+j]),
      .vld_i  (vld[DV0+j-1]),
      .side_i (dv_side[j]),
      .d_i    (dv_d[j]),
      .rem_i  (dv_rem[j]),
      .q_i    (dv_q[j]),
      .vld_o  (vld[DV0+j]),
      .side_o (dv_side[j+1]),
      .d_o    (dv_d[j+1]),
      .rem_o  (dv_rem[j+1]),
      .q_o    (dv_q[j+1])
    );
  end

  // reciprocal clamp and multiply
  vvu_pkg::side_t     sm_side;
  logic               sm_dzero;
  logic signed [64:0] sm_p [4];
  logic [QE-1:0]      qe;
  logic [31:0]        rc32;
  logic signed [32:0] rcs;

  always_comb begin
    qe   = QE'(dv_q[QW]);
    rc32 = (|qe[QE-1:32]) ? 32'hFFFF_FFFF : qe[31:0];
    rcs  = (dv_side[QW].op == vvu_pkg::OP_PERSP && dv_side[QW].a[3][31]) ?
           33'sd0 - $signed({1'b0, rc32}) : $signed({1'b0, rc32});
  end

  always_ff @(posedge clk_i) begin
    if (en[SM]) begin
      sm_side  <= dv_side[QW];
      sm_dzero <= (dv_d[QW] == '0);
      for (int i = 0; i < 4; i++) begin
        sm_p[i] <= $signed(dv_side[QW].a[i]) * rcs;
      end
    end
  end

  // final shift, clamp and select
  logic [31:0] r_d [4];
  logic        sat_d, dz_d;

  always_comb begin
    logic signed [64:0] sh;
    logic [32:0]        sr;
    logic               use_p;
    use_p = 1'b0;
    dz_d  = 1'b0;
    unique case (sm_side.op)
      vvu_pkg::OP_NORMALIZE: use_p = !sm_dzero;
      vvu_pkg::OP_PERSP: begin
        use_p = !sm_dzero;
        dz_d  = sm_dzero;
      end
      default: use_p = 1'b0;
    endcase
    sat_d = use_p ? 1'b0 : sm_side.esat;
    for (int i = 0; i < 4; i++) begin
      sh = sm_p[i] >>> FRAC_BITS;
      sr = vvu_pkg::sat66(66'(sh));
      if (use_p) begin
        r_d[i] = sr[31:0];
        sat_d  = sat_d | sr[32];
      end else if (dz_d || sm_side.op == vvu_pkg::OP_NORMALIZE) begin
        r_d[i] = '0;
      end else begin
        r_d[i] = sm_side.er[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      r_x_o       <= r_d[0];
      r_y_o       <= r_d[1];
      r_z_o       <= r_d[2];
      r_w_o       <= r_d[3];
      equal_o     <= sm_side.eq;
      div_zero_o  <= dz_d;
      saturated_o <= sat_d;
    end
  end

  `VVU_ASSERT(a_dz_zero, clk_i, rst_ni,
    out_valid_o && div_zero_o |-> r_x_o == 0 && r_w_o == 0 && !saturated_o,
    "divide by zero beat carries a nonzero result")
  `VVU_ASSERT(a_fill, clk_i, rst_ni,
    out_valid_o && !out_ready_i && in_ready_o |-> !(&vld),
    "input ready while every stage is full and stalled")
  `VVU_ASSERT(a_last_src, clk_i, rst_ni,
    $rose(vld[NS-1]) |-> $past(vld[NS-2]),
    "output valid rose without a beat in the multiply stage")

endmodule

// File: verif/vec4_vector_unit_checker.sv
// Checker for the vector unit: watches both channels, predicts each result
// beat from the accepted input beat and compares field by field.
// Depends on vvu_pkg for the operation codes.
`timescale 1ns / 1ps

module vec4_vector_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] a_w_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] b_w_i,
  input  logic signed [31:0] scalar_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] r_x_i,
  input  logic signed [31:0] r_y_i,
  input  logic signed [31:0] r_z_i,
  input  logic signed [31:0] r_w_i,
  input  logic               equal_i,
  input  logic               div_zero_i,
  input  logic               saturated_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int FRAC = int'(vvu_pkg::FRAC_BITS_DEF);

  typedef struct {
    logic [31:0] r [4];
    logic        eq;
    logic        dz;
    logic        sat;
  } vec_result_t;

  vec_result_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic sat);
    if (v > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [64:0] n);
    logic [64:0] lo, hi, mid;
    lo = 0;
    hi = 65'h1_0000_0000;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo[63:0];
  endfunction

  function automatic vec_result_t predict_vector(input vvu_pkg::op_e op,
      input logic signed [31:0] a [4], input logic signed [31:0] b [4],
      input logic signed [31:0] s);
    vec_result_t res;
    logic signed [127:0] wide;
    logic signed [127:0] rc;
    logic [64:0] sumsq;
    logic [63:0] len, mag, q;
    res.eq = 1'b1;
    res.dz = 1'b0;
    res.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res.r[i] = '0;
      if (a[i] != b[i]) res.eq = 1'b0;
    end
    rc = 0;
    case (op)
      vvu_pkg::OP_ADD: for (int i = 0; i < 4; i++)
        res.r[i] = clamp32(128'(a[i]) + 128'(b[i]), res.sat);
      vvu_pkg::OP_SUB: for (int i = 0; i < 4; i++)
        res.r[i] = clamp32(128'(a[i]) - 128'(b[i]), res.sat);
      vvu_pkg::OP_SCALE: for (int i = 0; i < 4; i++) begin
        wide = 128'(a[i]) * 128'(s);
        res.r[i] = clamp32(wide >>> FRAC, res.sat);
      end
      vvu_pkg::OP_NEGATE: for (int i = 0; i < 4; i++)
        res.r[i] = clamp32(-128'(a[i]), res.sat);
      vvu_pkg::OP_NORMALIZE: begin
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
          wide = 128'(a[i]) * 128'(a[i]);
          sumsq = sumsq + wide[64:0];
        end
        len = floor_sqrt(sumsq);
        if (len != 0) begin
          q = (64'd1 << (2 * FRAC)) / len;
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          rc = 128'(q);
        end
      end
      vvu_pkg::OP_PERSP: begin
        if (a[3] == 0) begin
          res.dz = 1'b1;
        end else begin
          mag = a[3] < 0 ? 64'(-65'(a[3])) : 64'(a[3]);
          q = (64'd1 << (2 * FRAC)) / mag;
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          rc = a[3] < 0 ? -128'(q) : 128'(q);
        end
      end
      default: ;
    endcase
    if (rc != 0) begin
      for (int i = 0; i < 4; i++) begin
        wide = 128'(a[i]) * rc;
        res.r[i] = clamp32(wide >>> FRAC, res.sat);
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    logic signed [31:0] av [4];
    logic signed [31:0] bv [4];
    vec_result_t exp_r;
    if (rst_ni && in_valid_i && in_ready_i) begin
      av = '{a_x_i, a_y_i, a_z_i, a_w_i};
      bv = '{b_x_i, b_y_i, b_z_i, b_w_i};
      expected_q.push_back(predict_vector(vvu_pkg::op_e'(operation_i), av, bv,
                                          scalar_i));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending");
        fail_count_o++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("r_x", exp_r.r[0], r_x_i);
        check_field("r_y", exp_r.r[1], r_y_i);
        check_field("r_z", exp_r.r[2], r_z_i);
        check_field("r_w", exp_r.r[3], r_w_i);
        check_field("equal", 32'(exp_r.eq), 32'(equal_i));
        check_field("div_zero", 32'(exp_r.dz), 32'(div_zero_i));
        check_field("saturated", 32'(exp_r.sat), 32'(saturated_i));
      end
    end
  end

endmodule

// File: verif/vec4_vector_unit_tb.sv
// Testbench top for the vector unit: drives directed and random vector
// operations with bursty valid and a stalling ready, and gives the verdict.
// Depends on vvu_pkg, vec4_vector_unit and vec4_vector_unit_checker.
`timescale 1ns / 1ps

module vec4_vector_unit_tb;

  localparam int LATENCY = 71;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         operation;
  logic signed [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] r_x, r_y, r_z, r_w;
  logic               equal, div_zero, saturated;
  int                 fail_count;
  int                 pending;

  vec4_vector_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z), .a_w_i(a_w),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z), .b_w_i(b_w), .scalar_i(scalar),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .r_x_o(r_x), .r_y_o(r_y),
    .r_z_o(r_z), .r_w_o(r_w), .equal_o(equal), .div_zero_o(div_zero),
    .saturated_o(saturated)
  );

  vec4_vector_unit_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z), .a_w_i(a_w),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z), .b_w_i(b_w), .scalar_i(scalar),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .r_x_i(r_x), .r_y_i(r_y),
    .r_z_i(r_z), .r_w_i(r_w), .equal_i(equal), .div_zero_i(div_zero),
    .saturated_i(saturated), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'($urandom_range(0, 8)) << 16;
      4: return -(32'($urandom_range(1, 8)) << 16);
      5: return 32'($signed(16'($urandom())));
      6: return 32'($urandom_range(0, 3)) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_vector(input logic [2:0] op, input logic [31:0] ax,
      input logic [31:0] ay, input logic [31:0] az, input logic [31:0] aw,
      input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
      input logic [31:0] bw, input logic [31:0] s);
    in_valid  <= 1'b1;
    operation <= op;
    a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
    b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
    scalar <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] av [4];
    logic [31:0] bv [4];
    logic [2:0]  op;
    op = 3'($urandom_range(0, 7));
    for (int i = 0; i < 4; i++) begin
      av[i] = pick_word();
      bv[i] = ($urandom_range(0, 5) == 0) ? av[i] : pick_word();
    end
    send_vector(op, av[0], av[1], av[2], av[3], bv[0], bv[1], bv[2], bv[3],
                pick_word());
  endtask

  // Receiver: stall on its own pattern, with calm stretches.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (($urandom_range(0, 3) == 0) && ($urandom_range(0, 99) < 70))
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    logic [31:0] mx, mn;
    int burst;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    rst_n = 1'b0;
    in_valid = 1'b0;
    operation = '0;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar} = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_vector(vvu_pkg::OP_ADD, mx, mx, mn, 1, 1, mx, mn, 1, 0);
    send_vector(vvu_pkg::OP_SUB, mn, mx, 0, 5, 1, mn, 0, 5, 0);
    send_vector(vvu_pkg::OP_SCALE, mx, mn, -1, 3 << 16, 0, 0, 0, 0, mx);
    send_vector(vvu_pkg::OP_SCALE, mx, mn, -1, 1, 0, 0, 0, 0, mn);
    send_vector(vvu_pkg::OP_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, 32'h0000_8000);
    send_vector(vvu_pkg::OP_NEGATE, mn, mx, 0, -1, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_NORMALIZE, 3 << 16, 4 << 16, 0, 0, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_NORMALIZE, 1, 0, 0, 0, 1, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_NORMALIZE, mn, mn, mn, mn, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_NORMALIZE, mx, mn, mx, mn, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_PERSP, 1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_PERSP, 1 << 16, 2 << 16, 3 << 16, 2 << 16,
                0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_PERSP, mx, mn, 5, 1, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_PERSP, mx, mn, 5, -1, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_PERSP, 7, -7, mx, mn, 0, 0, 0, 0, 0);
    send_vector(vvu_pkg::OP_EQUALS, 1, 2, 3, 4, 1, 2, 3, 4, 0);
    send_vector(vvu_pkg::OP_EQUALS, 1, 2, 3, 4, 1, 2, 3, 5, 0);
    send_vector(3'd7, mn, mx, 0, 1, mn, mx, 0, 1, 0);
    send_vector(3'd7, $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    in_valid <= 1'b0;

    // Hold until the pipeline has drained completely.
    wait (pending == 0);
    @(negedge clk);

    for (int n = 0; n < 1930; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 1930; k++, n++) send_random();
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end

    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("vec4_vector_unit_tb OK");
    else
      $display("vec4_vector_unit_tb NOT OK");
    $finish;
  end

  initial begin
    #4ms;
    $display("vec4_vector_unit_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/vvu_pkg.sv
rtl/vvu_sqrt_cell.sv
rtl/vvu_div_cell.sv
rtl/vec4_vector_unit.sv
verif/vec4_vector_unit_checker.sv
verif/vec4_vector_unit_tb.sv
